### hdl/gegenbauer_coefficient_generator_unit_assert.svh
// Assertion macros for the Gegenbauer coefficient generator.
// Expects clk and rst in the scope of each use; no other dependencies.
`ifndef GEGENBAUER_COEFFICIENT_GENERATOR_UNIT_ASSERT_SVH
`define GEGENBAUER_COEFFICIENT_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GCG_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GCG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/gcg_pkg.sv
// Shared types, constants and microcode ROM for the Gegenbauer coefficient generator.
// No dependencies; used by the stream interfaces and the top level.
package gcg_pkg;

  localparam int MAX_COEFS = 64;
  localparam int KW        = $clog2(MAX_COEFS);

  // Datapath widths derived from the index width
  localparam int FAC_W = KW + 18;
  localparam int A_W   = ((KW > 3) ? KW : 3) + 21;
  localparam int B_W   = ((KW > 4) ? KW : 4) + 20;

  // Divider: quotient register and bits retired per cycle
  localparam int DVD_W     = 48;
  localparam int DIV_RADIX = 2;
  localparam int DIV_STEPS = DVD_W / DIV_RADIX;
  localparam int DCW       = $clog2(DIV_STEPS);

  localparam int PC_W = 4;

  typedef logic signed [15:0] q15_t;
  typedef logic signed [15:0] q12_t;
  typedef logic [6:0]         count_t;
  typedef logic signed [31:0] coef_t;
  typedef logic [5:0]         index_t;
  typedef logic [KW-1:0]      k_t;
  typedef logic [PC_W-1:0]    pc_t;
  typedef logic [3:0]         op_t;
  typedef logic [1:0]         cond_t;

  localparam coef_t COEF_ONE = 32'sh0001_0000;
  localparam coef_t COEF_MAX = 32'sh7FFF_FFFF;
  localparam coef_t COEF_MIN = 32'sh8000_0000;

  // Datapath operations
  localparam op_t OP_NOP      = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;
  localparam op_t OP_EMIT     = 4'd2;
  localparam op_t OP_MUL_DU   = 4'd3;
  localparam op_t OP_RND_C1   = 4'd4;
  localparam op_t OP_MUL_A    = 4'd5;
  localparam op_t OP_RND_A    = 4'd6;
  localparam op_t OP_MUL_P    = 4'd7;
  localparam op_t OP_MUL_Q    = 4'd8;
  localparam op_t OP_SUB      = 4'd9;
  localparam op_t OP_ABS      = 4'd10;
  localparam op_t OP_DIV_PREP = 4'd11;
  localparam op_t OP_DIV_STEP = 4'd12;
  localparam op_t OP_FIN      = 4'd13;

  // Sequencing conditions
  localparam cond_t COND_NEXT = 2'd0;
  localparam cond_t COND_JUMP = 2'd1;
  localparam cond_t COND_LAST = 2'd2;  // last index -> idle, else target
  localparam cond_t COND_DIV  = 2'd3;  // divider busy -> target, else next

  // Program addresses
  localparam pc_t STEP_IDLE     = 4'd0;
  localparam pc_t STEP_EMIT_C0  = 4'd1;
  localparam pc_t STEP_MUL_DU   = 4'd2;
  localparam pc_t STEP_RND_C1   = 4'd3;
  localparam pc_t STEP_EMIT_C1  = 4'd4;
  localparam pc_t STEP_LOOP     = 4'd5;
  localparam pc_t STEP_RND_A    = 4'd6;
  localparam pc_t STEP_MUL_P    = 4'd7;
  localparam pc_t STEP_MUL_Q    = 4'd8;
  localparam pc_t STEP_SUB      = 4'd9;
  localparam pc_t STEP_ABS      = 4'd10;
  localparam pc_t STEP_DIV_PREP = 4'd11;
  localparam pc_t STEP_DIV      = 4'd12;
  localparam pc_t STEP_FIN      = 4'd13;
  localparam pc_t STEP_EMIT_CK  = 4'd14;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      STEP_IDLE:     w = '{OP_LOAD,     COND_JUMP, STEP_EMIT_C0};
      STEP_EMIT_C0:  w = '{OP_EMIT,     COND_LAST, STEP_MUL_DU};
      STEP_MUL_DU:   w = '{OP_MUL_DU,   COND_NEXT, STEP_IDLE};
      STEP_RND_C1:   w = '{OP_RND_C1,   COND_NEXT, STEP_IDLE};
      STEP_EMIT_C1:  w = '{OP_EMIT,     COND_LAST, STEP_LOOP};
      STEP_LOOP:     w = '{OP_MUL_A,    COND_NEXT, STEP_IDLE};
      STEP_RND_A:    w = '{OP_RND_A,    COND_NEXT, STEP_IDLE};
      STEP_MUL_P:    w = '{OP_MUL_P,    COND_NEXT, STEP_IDLE};
      STEP_MUL_Q:    w = '{OP_MUL_Q,    COND_NEXT, STEP_IDLE};
      STEP_SUB:      w = '{OP_SUB,      COND_NEXT, STEP_IDLE};
      STEP_ABS:      w = '{OP_ABS,      COND_NEXT, STEP_IDLE};
      STEP_DIV_PREP: w = '{OP_DIV_PREP, COND_NEXT, STEP_IDLE};
      STEP_DIV:      w = '{OP_DIV_STEP, COND_DIV,  STEP_DIV};
      STEP_FIN:      w = '{OP_FIN,      COND_NEXT, STEP_IDLE};
      STEP_EMIT_CK:  w = '{OP_EMIT,     COND_LAST, STEP_LOOP};
      default:       w = '{OP_NOP,      COND_JUMP, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/gcg_if.sv
// Valid/ready stream interfaces: request channel and coefficient channel.
// Depends on gcg_pkg for payload types.
interface gcg_req_if;
  import gcg_pkg::*;
  logic   valid;
  logic   ready;
  q15_t   u_cosine;
  q12_t   memory_param;
  count_t coef_count;
  modport source (output valid, u_cosine, memory_param, coef_count, input ready);
  modport sink   (input valid, u_cosine, memory_param, coef_count, output ready);
endinterface

interface gcg_coef_if;
  import gcg_pkg::*;
  logic   valid;
  logic   ready;
  coef_t  coef_value;
  index_t coef_index;
  logic   last_coef;
  logic   saturated;
  modport source (output valid, coef_value, coef_index, last_coef, saturated, input ready);
  modport sink   (input valid, coef_value, coef_index, last_coef, saturated, output ready);
endinterface

### hdl/gegenbauer_coefficient_generator_unit.sv
// Gegenbauer coefficient generator: microcoded sequencer over a shared
// multiply / round / serial-divide datapath. Depends on gcg_pkg, gcg_if
// and the assertion macro header.
//
// Usage: a request transaction on req (u_cosine Q1.15, memory_param Q3.12,
// coef_count) yields coef_count coefficient transactions on coef, C_0 first,
// in Q16.16 with index, last flag and saturation flag. A count of zero gives
// C_0 alone; counts above MAX_COEFS are clipped to it.
// One request is processed at a time; req.ready is high only while the
// sequencer sits at its idle step.
// Sequence: after acceptance the EMIT_C0 step registers C_0 in the output
// register; the MUL_DU, RND_C1 and EMIT_C1 steps give C_1, and each further C_k
// takes 7 control steps plus 24 steps of the 2-bit-per-cycle divider by k, plus
// clamp and emit. The next request is taken only once the sequencer is back at
// idle after the last coefficient has been emitted.
// The output is a single register: if coef.ready is low the emit step holds
// the sequencer until the pending transaction is taken, nothing is lost.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// any pending coefficient.
`include "gegenbauer_coefficient_generator_unit_assert.svh"

module gegenbauer_coefficient_generator_unit (
  input  logic       clk,
  input  logic       rst,
  gcg_req_if.sink    req,
  gcg_coef_if.source coef
);
  import gcg_pkg::*;

  function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
                                                   input int sh);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? -v : v;
    q   = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? $signed(-q) : $signed(q);
  endfunction

  // Sequencer
  pc_t    step;
  pc_t    step_next;
  uword_t uw;

  // Datapath registers
  q15_t                     latched_u;
  q12_t                     latched_d;
  k_t                       last_idx;
  k_t                       step_index;
  coef_t                    prev_coef;
  coef_t                    prev_prev_coef;
  logic                     sat;
  logic signed [63:0]       prod;
  logic signed [63:0]       acc;
  logic signed [A_W-1:0]    a_reg;
  logic signed [B_W-1:0]    b_reg;
  logic                     neg;
  logic [DVD_W-1:0]         dvd;
  logic [KW:0]              rem;
  logic [DCW-1:0]           div_cnt;

  // Output register
  logic   out_valid;
  coef_t  out_value;
  index_t out_index;
  logic   out_last;
  logic   out_sat;

  // Combinational datapath
  logic                       hold;
  logic                       emit_fire;
  logic                       is_last;
  logic [31:0]                cnt_wide;
  logic [31:0]                last_wide;
  logic [31:0]                k_wide;
  logic signed [31:0]         du;
  logic signed [63:0]         c1;
  logic signed [63:0]         a18;
  logic signed [FAC_W-1:0]    k_f;
  logic signed [FAC_W-1:0]    fac;
  logic signed [FAC_W+15:0]   fac_u;
  logic signed [B_W-1:0]      k_b;
  logic signed [B_W-1:0]      b18;
  logic signed [A_W+31:0]     mp;
  logic signed [B_W+31:0]     mq;
  logic [63:0]                biased;
  logic [KW:0]                rem_next;
  logic [DVD_W-1:0]           dvd_next;
  logic                       pos_over;
  logic                       neg_over;
  coef_t                      fin_val;

  assign uw        = ucode(step);
  assign is_last   = (step_index == last_idx);
  assign hold      = ((uw.op == OP_LOAD) && !req.valid) ||
                     ((uw.op == OP_EMIT) && out_valid && !coef.ready);
  assign emit_fire = (uw.op == OP_EMIT) && !hold;

  assign req.ready = (uw.op == OP_LOAD);

  always_comb begin
    step_next = step + PC_W'(1);
    case (uw.cond)
      COND_NEXT: step_next = step + PC_W'(1);
      COND_JUMP: step_next = uw.target;
      COND_LAST: step_next = is_last ? STEP_IDLE : uw.target;
      COND_DIV:  step_next = (div_cnt != DCW'(DIV_STEPS - 1)) ? uw.target
                                                             : step + PC_W'(1);
      default:   step_next = STEP_IDLE;
    endcase
    if (hold) begin
      step_next = step;
    end
  end

  // Zero count means one coefficient; counts beyond the limit are clipped
  always_comb begin
    cnt_wide = 32'(req.coef_count);
    if (cnt_wide == 32'd0) begin
      last_wide = 32'd0;
    end else if (cnt_wide > 32'(MAX_COEFS)) begin
      last_wide = 32'(MAX_COEFS - 1);
    end else begin
      last_wide = cnt_wide - 32'd1;
    end
  end

  assign k_wide = 32'(step_index);

  // C_1 = round(d*u / 2^10)
  assign du = latched_d * latched_u;
  assign c1 = round_shr(prod, 10);

  // a = 2*(k-1+d)*u in Q27; here step_index still holds k-1
  assign k_f   = signed'(FAC_W'(step_index));
  assign fac   = (k_f <<< 13) + (FAC_W'(latched_d) <<< 1);
  assign fac_u = fac * latched_u;
  assign a18   = round_shr(prod, 9);

  // b = (k-2+2d) in Q18; step_index holds k
  assign k_b = signed'(B_W'(step_index));
  assign b18 = (((k_b - B_W'(2)) <<< 12) + (B_W'(latched_d) <<< 1)) <<< 6;

  assign mp = a_reg * prev_coef;
  assign mq = b_reg * prev_prev_coef;

  // Round-half-up on the magnitude, then floor-divide by k
  assign biased = acc + (64'(step_index) << 17);

  always_comb begin
    logic [KW:0]      r;
    logic [DVD_W-1:0] q;
    r = rem;
    q = dvd;
    for (int i = 0; i < DIV_RADIX; i++) begin
      r = {r[KW-1:0], q[DVD_W-1]};
      q = {q[DVD_W-2:0], 1'b0};
      if (r >= {1'b0, step_index}) begin
        r    = r - {1'b0, step_index};
        q[0] = 1'b1;
      end
    end
    rem_next = r;
    dvd_next = q;
  end

  // Clamp to Q16.16: negative side reaches one further
  assign pos_over = |dvd[DVD_W-1:31];
  assign neg_over = (|dvd[DVD_W-1:32]) || (dvd[31] && (|dvd[30:0]));
  assign fin_val  = neg ? (neg_over ? COEF_MIN : -dvd[31:0])
                        : (pos_over ? COEF_MAX : dvd[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= STEP_IDLE;
      step_index <= '0;
      last_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      step <= step_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (coef.ready) begin
        out_valid <= 1'b0;
      end
      case (uw.op)
        OP_LOAD: begin
          if (!hold) begin
            latched_u      <= req.u_cosine;
            latched_d      <= req.memory_param;
            last_idx       <= last_wide[KW-1:0];
            step_index     <= '0;
            prev_coef      <= COEF_ONE;
            prev_prev_coef <= '0;
            sat            <= 1'b0;
          end
        end
        OP_EMIT: begin
          if (!hold) begin
            out_value <= prev_coef;
            out_index <= k_wide[5:0];
            out_last  <= is_last;
            out_sat   <= sat;
          end
        end
        OP_MUL_DU: begin
          prod <= 64'(du);
        end
        OP_RND_C1: begin
          prev_prev_coef <= prev_coef;
          prev_coef      <= c1[31:0];
          step_index     <= step_index + KW'(1);
          sat            <= 1'b0;
        end
        OP_MUL_A: begin
          prod       <= 64'(fac_u);
          step_index <= step_index + KW'(1);
        end
        OP_RND_A: begin
          a_reg <= a18[A_W-1:0];
          b_reg <= b18;
        end
        OP_MUL_P: begin
          prod <= 64'(mp);
        end
        OP_MUL_Q: begin
          acc  <= prod;
          prod <= 64'(mq);
        end
        OP_SUB: begin
          acc <= acc - prod;
        end
        OP_ABS: begin
          neg <= acc[63];
          acc <= acc[63] ? -acc : acc;
        end
        OP_DIV_PREP: begin
          dvd     <= DVD_W'(biased >> 18);
          rem     <= '0;
          div_cnt <= '0;
        end
        OP_DIV_STEP: begin
          dvd     <= dvd_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + DCW'(1);
        end
        OP_FIN: begin
          prev_prev_coef <= prev_coef;
          prev_coef      <= fin_val;
          sat            <= neg ? neg_over : pos_over;
        end
        default: begin
        end
      endcase
    end
  end

  assign coef.valid      = out_valid;
  assign coef.coef_value = out_value;
  assign coef.coef_index = out_index;
  assign coef.last_coef  = out_last;
  assign coef.saturated  = out_sat;

  `GCG_ASSERT_NOW(a_rem_below_k, uw.op == OP_DIV_STEP,
                  rem < (KW+1)'(step_index), "divider remainder not below k")
  `GCG_ASSERT_NOW(a_index_in_range, step != STEP_IDLE,
                  step_index <= last_idx, "coefficient index beyond request count")
  `GCG_ASSERT_NEXT(a_load_starts_c0, req.valid && req.ready,
                   uw.op == OP_EMIT && step_index == '0 && prev_coef == COEF_ONE,
                   "request not followed by C0 emit")
  `GCG_ASSERT_NEXT(a_last_to_idle, emit_fire && is_last,
                   step == STEP_IDLE, "sequencer not idle after final coefficient")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for gegenbauer_coefficient_generator_unit: directed table, then random
// requests under varying back-pressure. Depends on gcg_pkg, gcg_if and the unit itself.
module tb_top;
  import gcg_pkg::*;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int TAIL_CYCLES      = 80;
  localparam int HOLD_CYCLES      = 400;
  localparam int RANDOM_PER_PHASE = 52;
  localparam int N_DIRECTED       = 22;

  typedef struct {
    coef_t  value;
    index_t index;
    logic   last;
    logic   sat;
  } coef_rec_t;

  // pin: the final coefficient of the row is typed in rather than predicted
  typedef struct {
    q15_t   u;
    q12_t   d;
    count_t n;
    bit     pin;
    coef_t  pin_value;
  } req_row_t;

  logic clk;
  logic rst;

  gcg_req_if  req_ch ();
  gcg_coef_if coef_ch ();

  gegenbauer_coefficient_generator_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .coef (coef_ch)
  );

  coef_rec_t coef_expect_q[$];
  int        errors;
  int        requests_done;
  int        coefs_checked;
  int        sat_seen;
  int        input_stall_cycles;
  int        send_idle_pct;
  int        stall_pct;
  int        hold_left;

  req_row_t directed_rows [N_DIRECTED] = '{
    '{16'sh0000, 16'sh0000, 7'd0,   1'b1, COEF_ONE},        // zero count -> C_0 only
    '{16'sh7FFF, 16'sh7FFF, 7'd1,   1'b1, COEF_ONE},
    '{16'sh8000, 16'sh8000, 7'd2,   1'b1, 32'sh0010_0000},
    '{16'sh8000, 16'sh7FFF, 7'd2,   1'b1, -32'sd1048544},
    '{16'sh7FFF, 16'sh0000, 7'd2,   1'b1, 32'sh0000_0000},
    '{16'sh0000, 16'sh8000, 7'd2,   1'b1, 32'sh0000_0000},
    '{16'sh0001, 16'sh0001, 7'd2,   1'b1, 32'sh0000_0000},
    '{16'sh0200, 16'sh0001, 7'd2,   1'b1, 32'sh0000_0001},  // tie rounds away from zero
    '{-16'sh0200, 16'sh0001, 7'd2,  1'b1, -32'sh0000_0001},
    '{16'sh4000, 16'sh1000, 7'd8,   1'b0, '0},
    '{16'sh7FFF, 16'sh7FFF, 7'd64,  1'b0, '0},              // runs into positive clamp
    '{16'sh8000, 16'sh7FFF, 7'd64,  1'b0, '0},              // alternating clamp
    '{16'sh8000, 16'sh8000, 7'd64,  1'b0, '0},
    '{16'sh0000, 16'sh3039, 7'd10,  1'b0, '0},
    '{16'sh2EE0, 16'sh0800, 7'd127, 1'b0, '0},              // count above the maximum
    '{-16'sd5000, -16'sd3000, 7'd65, 1'b0, '0},
    '{16'sh7FFF, 16'sh8000, 7'd64,  1'b0, '0},
    '{-16'sh0001, 16'sh0001, 7'd3,  1'b0, '0},
    '{16'sh7FFF, 16'sh0800, 7'd40,  1'b0, '0},
    '{16'sh8000, 16'sh4000, 7'd64,  1'b0, '0},
    '{16'sh5A82, -16'sh0800, 7'd20, 1'b0, '0},
    '{16'sh0000, 16'sh0000, 7'd64,  1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Round to nearest, ties away from zero; den is positive
  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  task automatic predict_coefs(q15_t u, q12_t d, count_t n_raw, bit pin, coef_t pin_value);
    longint uu, dd, c_prev, c_prev2, a_q18, b_q18, acc, c_next;
    int     n;
    logic   clipped;
    uu = u;
    dd = d;
    n  = n_raw;
    if (n == 0) n = 1;
    if (n > MAX_COEFS) n = MAX_COEFS;
    coef_expect_q.push_back('{(pin && n == 1) ? pin_value : COEF_ONE, index_t'(0), n == 1, 1'b0});
    if (n > 1) begin
      c_prev2 = longint'(COEF_ONE);
      c_prev  = round_div(dd * uu, 1024);
      coef_expect_q.push_back('{(pin && n == 2) ? pin_value : coef_t'(c_prev), index_t'(1),
                                n == 2, 1'b0});
      for (int k = 2; k < n; k++) begin
        a_q18   = round_div(2 * (longint'(k - 1) * 4096 + dd) * uu, 512);
        b_q18   = (longint'(k - 2) * 4096 + 2 * dd) * 64;
        acc     = a_q18 * c_prev - b_q18 * c_prev2;
        c_next  = round_div(acc, longint'(k) * 262144);
        clipped = 1'b0;
        if (c_next > longint'(COEF_MAX)) begin
          c_next  = longint'(COEF_MAX);
          clipped = 1'b1;
        end else if (c_next < longint'(COEF_MIN)) begin
          c_next  = longint'(COEF_MIN);
          clipped = 1'b1;
        end
        c_prev2 = c_prev;
        c_prev  = c_next;
        coef_expect_q.push_back('{(pin && k == n - 1) ? pin_value : coef_t'(c_next),
                                  index_t'(k), k == n - 1, clipped});
      end
    end
  endtask

  task automatic check_coef();
    coef_rec_t want;
    if (coef_expect_q.size() == 0) begin
      $error("unexpected coefficient: index %0d value %0d", coef_ch.coef_index,
             coef_ch.coef_value);
      errors++;
    end else begin
      want = coef_expect_q.pop_front();
      coefs_checked++;
      if (coef_ch.saturated === 1'b1) sat_seen++;
      if (coef_ch.coef_value !== want.value) begin
        $error("coef_value: expected %0d, got %0d", want.value, coef_ch.coef_value);
        errors++;
      end
      if (coef_ch.coef_index !== want.index) begin
        $error("coef_index: expected %0d, got %0d", want.index, coef_ch.coef_index);
        errors++;
      end
      if (coef_ch.last_coef !== want.last) begin
        $error("last_coef: expected %0b, got %0b", want.last, coef_ch.last_coef);
        errors++;
      end
      if (coef_ch.saturated !== want.sat) begin
        $error("saturated: expected %0b, got %0b", want.sat, coef_ch.saturated);
        errors++;
      end
    end
  endtask

  task automatic offer_request(q15_t u, q12_t d, count_t n, bit pin, coef_t pin_value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.u_cosine     <= u;
    req_ch.memory_param <= d;
    req_ch.coef_count   <= n;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    predict_coefs(u, d, n, pin, pin_value);
    requests_done++;
  endtask

  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    while (coef_expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic q15_t pick_u();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return q15_t'($urandom_range(28000, 32767));
      3:       return -q15_t'($urandom_range(28000, 32767));
      default: return q15_t'($urandom);
    endcase
  endfunction

  function automatic q12_t pick_d();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3, 4: return q12_t'(int'($urandom_range(0, 16384)) - 8192);  // |d| at most two
      default: return q12_t'($urandom);
    endcase
  endfunction

  // Mostly short requests; a few run to the maximum or past it
  function automatic count_t pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 4) return count_t'(0);
    else if (r < 45) return count_t'($urandom_range(1, 4));
    else if (r < 85) return count_t'($urandom_range(5, 16));
    else if (r < 95) return count_t'($urandom_range(17, 63));
    else return count_t'($urandom_range(64, 127));
  endfunction

  // Result side: checks each transaction and drives ready, with an optional long hold-off
  initial begin
    coef_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (coef_ch.valid === 1'b1 && coef_ch.ready === 1'b1) check_coef();
      if (hold_left > 0) begin
        hold_left--;
        coef_ch.ready <= 1'b0;
      end else begin
        coef_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (coef_ch.valid === 1'b1 && coef_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no transaction for %0d cycles, %0d coefficients outstanding", WATCHDOG_LIMIT,
           coef_expect_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    errors             = 0;
    requests_done      = 0;
    coefs_checked      = 0;
    sat_seen           = 0;
    input_stall_cycles = 0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    hold_left          = 0;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.u_cosine     <= '0;
    req_ch.memory_param <= '0;
    req_ch.coef_count   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_request(directed_rows[i].u, directed_rows[i].d, directed_rows[i].n,
                    directed_rows[i].pin, directed_rows[i].pin_value);
    wait_for_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  hold_left = HOLD_CYCLES; end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      repeat (RANDOM_PER_PHASE) offer_request(pick_u(), pick_d(), pick_count(), 1'b0, '0);
      wait_for_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d requests and %0d coefficients, %0d of them clamped;",
             requests_done, coefs_checked, sat_seen);
    $display("request channel was held off for %0d cycles.", input_stall_cycles);
    if (errors == 0 && coef_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
